// ----- rtl/node_ref_delta_histogram_defines.svh -----
// assertion macros for the node reference delta histogram
`ifndef NODE_REF_DELTA_HISTOGRAM_DEFINES_SVH
`define NODE_REF_DELTA_HISTOGRAM_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NDH_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ndh check failed");

// next-cycle implication, sampled on clk, off during reset
`define NDH_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ndh check failed");

`endif

// ----- rtl/ndh_pkg.sv -----
// shared types, constants and helpers of the node reference delta histogram
`timescale 1ns / 1ps

package ndh_pkg;

	localparam int NUM_BINS    = 32;
	localparam int COUNT_WIDTH = 48;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int OUT_W       = 48;
	localparam int REF_W       = 63;
	localparam int DIFF_W      = REF_W + 1;
	localparam int SEL_W       = 5;
	localparam int CODE_W      = 4;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// operation codes of an input beat
	localparam logic [1:0] OP_NODE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// magnitude limits and range bin codes
	localparam logic [DIFF_W-1:0] SMALL_LIMIT = DIFF_W'(9);
	localparam logic [DIFF_W-1:0] RANGE_A     = DIFF_W'(127);
	localparam logic [DIFF_W-1:0] RANGE_B     = DIFF_W'(255);
	localparam logic [DIFF_W-1:0] RANGE_C     = DIFF_W'(65536);
	localparam logic [CODE_W-1:0] CODE_A      = CODE_W'(10);
	localparam logic [CODE_W-1:0] CODE_B      = CODE_W'(11);
	localparam logic [CODE_W-1:0] CODE_C      = CODE_W'(12);
	localparam logic [CODE_W-1:0] CODE_FAR    = CODE_W'(13);
	localparam logic [BIN_W-1:0]  NEG_OFFSET  = BIN_W'(16);

	typedef enum logic [1:0] {
		POS_NONE,
		POS_ONE,
		POS_MANY
	} pos_t;

	typedef enum logic [1:0] {
		ACT_IDLE,
		ACT_COUNT,
		ACT_READ,
		ACT_CLEAR
	} act_t;

	// work handed from the delta stage to the counter stage
	typedef struct packed {
		act_t             act;
		logic [BIN_W-1:0] bin;
		logic             bin_ok;
		logic             way_inc;
		logic [1:0]       node_add;
	} ndh_cmd_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] c,
			input logic [1:0] n);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, c} + (COUNT_WIDTH + 1)'(n);
		if (s > {1'b0, CNT_MAX}) begin
			return CNT_MAX;
		end
		return s[COUNT_WIDTH-1:0];
	endfunction

endpackage

// ----- rtl/ndh_delta.sv -----
// stage 1: input register, way tracking and delta bin classification
`timescale 1ns / 1ps

module ndh_delta import ndh_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    advance,
	input  logic [1:0]              operation,
	input  logic signed [REF_W-1:0] node_ref,
	input  logic                    first_of_way,
	input  logic [SEL_W-1:0]        bin_select,
	output ndh_cmd_t                cmd
);

	logic [1:0]       op_s1;
	logic [REF_W-1:0] ref_s1;
	logic             first_s1;
	logic [SEL_W-1:0] sel_s1;

	logic [REF_W-1:0] prev_q;
	pos_t             pos_q;

	logic [DIFF_W-1:0] cur_ext;
	logic [DIFF_W-1:0] prev_ext;
	logic [DIFF_W-1:0] d_fwd;
	logic [DIFF_W-1:0] d_rev;
	logic [DIFF_W-1:0] mag;
	logic              neg;
	logic [CODE_W-1:0] code;
	logic [BIN_W-1:0]  delta_bin;
	logic              counted;

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1    <= operation;
			ref_s1   <= node_ref;
			first_s1 <= first_of_way;
			sel_s1   <= bin_select;
		end
	end

	// both directions in parallel so the magnitude needs no second carry chain
	always_comb begin
		cur_ext  = {ref_s1[REF_W-1], ref_s1};
		prev_ext = {prev_q[REF_W-1], prev_q};
		d_fwd    = cur_ext - prev_ext;
		d_rev    = prev_ext - cur_ext;
		neg      = d_fwd[DIFF_W-1];
		mag      = neg ? d_rev : d_fwd;
		if (mag <= SMALL_LIMIT) begin
			code = mag[CODE_W-1:0];
		end else if (mag <= RANGE_A) begin
			code = CODE_A;
		end else if (mag <= RANGE_B) begin
			code = CODE_B;
		end else if (mag <= RANGE_C) begin
			code = CODE_C;
		end else begin
			code = CODE_FAR;
		end
		delta_bin = BIN_W'(code) + (neg ? NEG_OFFSET : '0);
	end

	// a node with no way open starts one
	assign counted = !first_s1 && (pos_q != POS_NONE);

	always_comb begin
		cmd = '{act: ACT_IDLE, bin: '0, bin_ok: 1'b0, way_inc: 1'b0, node_add: 2'd0};
		case (op_s1)
			OP_NODE: begin
				if (counted) begin
					cmd.act      = ACT_COUNT;
					cmd.bin      = delta_bin;
					cmd.bin_ok   = 32'(delta_bin) < NUM_BINS;
					cmd.way_inc  = (pos_q == POS_ONE);
					cmd.node_add = (pos_q == POS_ONE) ? 2'd2 : 2'd1;
				end
			end
			OP_READ: begin
				cmd.act    = ACT_READ;
				cmd.bin    = BIN_W'(sel_s1);
				cmd.bin_ok = 32'(sel_s1) < NUM_BINS;
			end
			OP_CLEAR: begin
				cmd.act = ACT_CLEAR;
			end
			default: begin
				cmd.act = ACT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			pos_q  <= POS_NONE;
		end else if (advance && (op_s1 == OP_NODE)) begin
			prev_q <= ref_s1;
			pos_q  <= counted ? POS_MANY : POS_ONE;
		end
	end

endmodule

// ----- rtl/ndh_count.sv -----
// stage 2: bin and total counters, clear and read
`timescale 1ns / 1ps

module ndh_count import ndh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             retire,
	input  ndh_cmd_t         cmd,
	output logic             is_read,
	output logic [OUT_W-1:0] rd_bin,
	output logic [OUT_W-1:0] rd_way,
	output logic [OUT_W-1:0] rd_node
);

	ndh_cmd_t               cmd_s2;
	logic [COUNT_WIDTH-1:0] bins_q [NUM_BINS];
	logic [COUNT_WIDTH-1:0] ways_q;
	logic [COUNT_WIDTH-1:0] nodes_q;
	logic                   do_count;
	logic                   do_clear;

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s2 <= cmd;
		end
	end

	assign do_count = retire && (cmd_s2.act == ACT_COUNT);
	assign do_clear = retire && (cmd_s2.act == ACT_CLEAR);

	// each bin owns its incrementer; on a count only the addressed one moves, a clear zeroes all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
			ways_q  <= '0;
			nodes_q <= '0;
		end else if (do_clear) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
			ways_q  <= '0;
			nodes_q <= '0;
		end else if (do_count) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				if (cmd_s2.bin_ok && (cmd_s2.bin == BIN_W'(i))) begin
					bins_q[i] <= sat_add(bins_q[i], 2'd1);
				end
			end
			if (cmd_s2.way_inc) begin
				ways_q <= sat_add(ways_q, 2'd1);
			end
			nodes_q <= sat_add(nodes_q, cmd_s2.node_add);
		end
	end

	assign is_read = (cmd_s2.act == ACT_READ);
	assign rd_bin  = cmd_s2.bin_ok ? OUT_W'(bins_q[cmd_s2.bin]) : '0;
	assign rd_way  = OUT_W'(ways_q);
	assign rd_node = OUT_W'(nodes_q);

endmodule

// ----- rtl/node_ref_delta_histogram.sv -----
// top level of the node reference delta histogram
//
//  channel   valid          ready          payload
//  item      item_valid     item_ready     operation, node_ref, first_of_way, bin_select
//  result    result_valid   result_ready   bin_count, way_total, node_total
//
// one item per cycle sustained while no read waits on a stalled result
// path: input register, delta and bin pick, counter update or read, result register
// a node's counts are visible to a read accepted in the very next cycle
// reset clears all counters and way tracking at once; no clearing pass
// a stalled result holds in its register while stages 1 and 2 keep filling
`timescale 1ns / 1ps

module node_ref_delta_histogram import ndh_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [1:0]              operation,
	input  logic signed [REF_W-1:0] node_ref,
	input  logic                    first_of_way,
	input  logic [SEL_W-1:0]        bin_select,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [OUT_W-1:0]        bin_count,
	output logic [OUT_W-1:0]        way_total,
	output logic [OUT_W-1:0]        node_total
);

	logic s1_valid_q;
	logic s2_valid_q;
	logic res_valid_q;
	logic accept;
	logic s1_advance;
	logic s2_leave;
	logic s2_is_read;

	ndh_cmd_t         cmd;
	logic [OUT_W-1:0] rd_bin;
	logic [OUT_W-1:0] rd_way;
	logic [OUT_W-1:0] rd_node;
	logic [OUT_W-1:0] bin_count_q;
	logic [OUT_W-1:0] way_total_q;
	logic [OUT_W-1:0] node_total_q;

	// only a read needs the result register to be free
	assign s2_leave   = s2_valid_q && (!s2_is_read || !res_valid_q || result_ready);
	assign s1_advance = s1_valid_q && (!s2_valid_q || s2_leave);
	assign item_ready = !s1_valid_q || s1_advance;
	assign accept     = item_valid && item_ready;

	ndh_delta u_delta (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.advance      (s1_advance),
		.operation    (operation),
		.node_ref     (node_ref),
		.first_of_way (first_of_way),
		.bin_select   (bin_select),
		.cmd          (cmd)
	);

	ndh_count u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (s1_advance),
		.retire  (s2_leave),
		.cmd     (cmd),
		.is_read (s2_is_read),
		.rd_bin  (rd_bin),
		.rd_way  (rd_way),
		.rd_node (rd_node)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_advance) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_advance) begin
				s2_valid_q <= 1'b1;
			end else if (s2_leave) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_leave && s2_is_read) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_leave && s2_is_read) begin
			bin_count_q  <= rd_bin;
			way_total_q  <= rd_way;
			node_total_q <= rd_node;
		end
	end

	assign result_valid = res_valid_q;
	assign bin_count    = bin_count_q;
	assign way_total    = way_total_q;
	assign node_total   = node_total_q;

endmodule

// ----- rtl/ndh_checker.sv -----
// port-level checks of the node reference delta histogram, bound to the top level
`timescale 1ns / 1ps
`include "node_ref_delta_histogram_defines.svh"

module ndh_checker import ndh_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input logic [OUT_W-1:0] bin_count,
	input logic [OUT_W-1:0] way_total,
	input logic [OUT_W-1:0] node_total
);

	// a stalled result beat holds
	`NDH_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(bin_count) && $stable(way_total) && $stable(node_total))

	// every counted way brings at least its own nodes
	`NDH_ASSERT_IMPL(a_nodes_cover_ways, result_valid, node_total >= way_total)

	// a counted way always adds two nodes
	`NDH_ASSERT_IMPL(a_way_has_two_nodes, result_valid && (way_total != '0), node_total >= OUT_W'(2))

	// a saturated way total stays saturated in a back-to-back result unless a clear brought it to zero
	`NDH_ASSERT_NEXT(a_back_to_back_ways, result_valid && result_ready && (way_total == '1), !result_valid || (way_total == '1) || (way_total == '0))

endmodule

bind node_ref_delta_histogram ndh_checker u_ndh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.bin_count    (bin_count),
	.way_total    (way_total),
	.node_total   (node_total)
);
